// ===== rtl/ostep_pkg.sv =====
// ----------------------------------------------------------------------------
// ostep_pkg
// Shared types and constants of the one-shot table envelope player: request
// op codes, register indexes, field widths and default parameter values.
// ----------------------------------------------------------------------------
package ostep_pkg;

  localparam int TABLE_DEPTH_DEF   = 1024;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int STEP_W    = 26;
  localparam int LAST_W    = 10;
  localparam int VALUE_W   = 16;
  localparam int LEFT_W    = 10;
  localparam int LEVEL_W   = 15;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [STEP_W-1:0] PHASE_STEP_RST = STEP_W'(65536);
  localparam logic [LAST_W-1:0] LAST_INDEX_RST = LAST_W'(1023);
  localparam int                LEVEL_ONE      = 16384;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RESTART = 2'd2,
    OP_CLOSE   = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = 2'd1;

  typedef struct packed {
    logic fire;
    logic wrapped;
  } tick_ctl_t;

endpackage

// ===== rtl/ostep_phase.sv =====
// ----------------------------------------------------------------------------
// ostep_phase
// Phase accumulator, write pointer and read index generation. Decodes each
// accepted request, updates phase and pointer, and issues table accesses.
// ----------------------------------------------------------------------------
module ostep_phase
  import ostep_pkg::*;
#(
  parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req_fire,
  input  logic [OP_W-1:0]          req_op,
  input  logic [VALUE_W-1:0]       req_value,
  input  logic [LEFT_W-1:0]        req_left,
  input  logic [STEP_W-1:0]        phase_step,
  input  logic [LAST_W-1:0]        last_index,
  output logic                     wr_en,
  output logic [IDX_W-1:0]         wr_addr,
  output logic [VALUE_W-1:0]       wr_data,
  output logic [IDX_W-1:0]         rd_addr0,
  output logic [IDX_W-1:0]         rd_addr1,
  output logic [FRACTION_BITS-1:0] frac,
  output tick_ctl_t                tick_ctl
);

  localparam int PH_W   = LAST_W + FRACTION_BITS;
  localparam int NEXT_W = ((PH_W > STEP_W) ? PH_W : STEP_W) + 1;
  localparam int CMP_W  = (IDX_W > LAST_W) ? IDX_W : LAST_W;
  localparam logic [CMP_W-1:0] DEPTH_M1 = CMP_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] WP_LAST  = IDX_W'(TABLE_DEPTH - 1);

  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [IDX_W-1:0]  wp_r, wp_nxt;
  op_t               op;
  logic [CMP_W-1:0]  last_ext, eff_wide, idx0_ext, idx1_ext;
  logic [LAST_W-1:0] eff_last, i0_raw, i0, i1, close_dist;
  logic [LAST_W:0]   i1_sum;
  logic [NEXT_W-1:0] next_phase, limit;
  logic              wrap;

  assign op = op_t'(req_op);

  always_comb begin
    last_ext   = CMP_W'(last_index);
    eff_wide   = (last_ext > DEPTH_M1) ? DEPTH_M1 : last_ext;
    eff_last   = eff_wide[LAST_W-1:0];

    i0_raw     = phase_r[PH_W-1:FRACTION_BITS];
    i0         = (i0_raw > eff_last) ? eff_last : i0_raw;
    i1_sum     = {1'b0, i0} + 1'b1;
    i1         = (i1_sum > {1'b0, eff_last}) ? eff_last : i1_sum[LAST_W-1:0];
    idx0_ext   = CMP_W'(i0);
    idx1_ext   = CMP_W'(i1);

    next_phase = NEXT_W'(phase_r) + NEXT_W'(phase_step);
    limit      = NEXT_W'(eff_last) << FRACTION_BITS;
    wrap       = next_phase > limit;
    close_dist = eff_last - req_left;
  end

  always_comb begin
    phase_nxt = phase_r;
    wp_nxt    = wp_r;
    if (req_fire) begin
      case (op)
        OP_TICK:    phase_nxt = wrap ? '0 : next_phase[PH_W-1:0];
        OP_WRITE:   wp_nxt = (wp_r == WP_LAST) ? '0 : wp_r + 1'b1;
        OP_RESTART: wp_nxt = '0;
        OP_CLOSE:   phase_nxt = (req_left >= eff_last) ? '0
                                : PH_W'(close_dist) << FRACTION_BITS;
        default:    phase_nxt = phase_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      wp_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      wp_r    <= wp_nxt;
    end
  end

  assign wr_en            = req_fire && (op == OP_WRITE);
  assign wr_addr          = wp_r;
  assign wr_data          = req_value;
  assign rd_addr0         = idx0_ext[IDX_W-1:0];
  assign rd_addr1         = idx1_ext[IDX_W-1:0];
  assign frac             = phase_r[FRACTION_BITS-1:0];
  assign tick_ctl.fire    = req_fire && (op == OP_TICK);
  assign tick_ctl.wrapped = wrap;

endmodule

// ===== rtl/ostep_table.sv =====
// ----------------------------------------------------------------------------
// ostep_table
// Envelope table memory: one write port, two read ports with registered
// read data, read on each sample tick.
// ----------------------------------------------------------------------------
module ostep_table
  import ostep_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr0,
  input  logic [IDX_W-1:0]   rd_addr1,
  output logic [VALUE_W-1:0] rd_data0,
  output logic [VALUE_W-1:0] rd_data1
);

  logic [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic [VALUE_W-1:0] rd_data0_r, rd_data1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0_r <= mem[rd_addr0];
      rd_data1_r <= mem[rd_addr1];
    end
  end

  assign rd_data0 = rd_data0_r;
  assign rd_data1 = rd_data1_r;

endmodule

// ===== rtl/ostep_interp.sv =====
// ----------------------------------------------------------------------------
// ostep_interp
// Linear interpolation between two neighbouring table words, rounding,
// clamping to 0..1.0 and the result register with its handshake.
// ----------------------------------------------------------------------------
module ostep_interp
  import ostep_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tick_ctl_t                tick_ctl,
  input  logic [FRACTION_BITS-1:0] frac,
  input  logic [VALUE_W-1:0]       rd_data0,
  input  logic [VALUE_W-1:0]       rd_data1,
  output logic                     take,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [LEVEL_W-1:0]       out_level,
  output logic                     out_wrapped
);

  localparam int DIFF_W = VALUE_W + 1;
  localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
  localparam int LVL_W  = VALUE_W + 3;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRACTION_BITS - 1);
  localparam logic signed [LVL_W-1:0]  LVL_ONE    = LVL_W'(LEVEL_ONE);

  logic                     s1_valid_r, s1_valid_nxt;
  logic                     s1_wrapped_r;
  logic [FRACTION_BITS-1:0] s1_frac_r;
  logic                     out_valid_r;
  logic [LEVEL_W-1:0]       level_r, level_nxt;
  logic                     wrapped_r;
  logic                     adv_out;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod, rounded, shifted;
  logic signed [LVL_W-1:0]  lvl;

  assign adv_out = !out_valid_r || out_ready;
  assign take    = !s1_valid_r || adv_out;

  assign s1_valid_nxt = take ? tick_ctl.fire : s1_valid_r;

  always_comb begin
    diff    = $signed({rd_data1[VALUE_W-1], rd_data1}) - $signed({rd_data0[VALUE_W-1], rd_data0});
    prod    = diff * $signed({1'b0, s1_frac_r});
    rounded = prod + ROUND_HALF;
    shifted = rounded >>> FRACTION_BITS;
    lvl     = $signed({{(LVL_W-VALUE_W){rd_data0[VALUE_W-1]}}, rd_data0})
              + shifted[LVL_W-1:0];
    if (lvl < 0) begin
      level_nxt = '0;
    end else if (lvl > LVL_ONE) begin
      level_nxt = LVL_ONE[LEVEL_W-1:0];
    end else begin
      level_nxt = lvl[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_ctl.fire) begin
      s1_frac_r    <= frac;
      s1_wrapped_r <= tick_ctl.wrapped;
    end
    if (adv_out && s1_valid_r) begin
      level_r   <= level_nxt;
      wrapped_r <= s1_wrapped_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_level   = level_r;
  assign out_wrapped = wrapped_r;

endmodule

// ===== rtl/one_shot_table_envelope_player_core.sv =====
// ----------------------------------------------------------------------------
// one_shot_table_envelope_player_core
// Table envelope player: table loading, phase accumulation and linearly
// interpolated playback, with a register write port for step and length.
// ----------------------------------------------------------------------------
// Pipeline: two register stages, the table read data and the result register.
// Throughput: one request per cycle unless out_ready stalls the result path; the
// phase accumulator is fed back from its own register and the table read port is
// registered ahead of the interpolator. Write, restart and close requests produce no result.
// Reset: synchronous, active low; clears phase, write pointer, pipeline valids
// and restores phase_step and last_index. The table is not cleared.
module one_shot_table_envelope_player_core
  import ostep_pkg::*;
#(
  parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_op,
  input  logic [VALUE_W-1:0]   in_write_value,
  input  logic [LEFT_W-1:0]    in_samples_left,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LEVEL_W-1:0]   out_level,
  output logic                 out_wrapped,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STEP_W-1:0]    cfg_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [STEP_W-1:0]        phase_step_r;
  logic [LAST_W-1:0]        last_index_r;
  logic                     cfg_fire, in_fire, take;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr, rd_addr0, rd_addr1;
  logic [VALUE_W-1:0]       wr_data, rd_data0, rd_data1;
  logic [FRACTION_BITS-1:0] frac;
  tick_ctl_t                tick_ctl;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = take;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RST;
      last_index_r <= LAST_INDEX_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_PHASE_STEP: phase_step_r <= cfg_data;
        REG_LAST_INDEX: last_index_r <= cfg_data[LAST_W-1:0];
        default: ;
      endcase
    end
  end

  ostep_phase #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_fire   (in_fire),
    .req_op     (in_op),
    .req_value  (in_write_value),
    .req_left   (in_samples_left),
    .phase_step (phase_step_r),
    .last_index (last_index_r),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr0   (rd_addr0),
    .rd_addr1   (rd_addr1),
    .frac       (frac),
    .tick_ctl   (tick_ctl)
  );

  ostep_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (tick_ctl.fire),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  ostep_interp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_interp (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_ctl    (tick_ctl),
    .frac        (frac),
    .rd_data0    (rd_data0),
    .rd_data1    (rd_data1),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_level   (out_level),
    .out_wrapped (out_wrapped)
  );

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level <= LEVEL_W'(LEVEL_ONE)))
    else $error("level above 1.0");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_step_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_fire && (cfg_index == REG_PHASE_STEP)) |=> (phase_step_r == $past(cfg_data)))
    else $error("phase_step write lost");

  a_tick_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    tick_ctl.fire |-> (in_fire && !wr_en))
    else $error("table read outside an accepted tick");

endmodule
